@@ rtl/core/hdsr_pkg.sv @@
// Shared types and constants for the hashed defect strip reachability core.
`default_nettype none

package hdsr_pkg;

    // Build maximum for the strip height.
    localparam int DEFAULT_MAX_STRIP_WIDTH = 8;

    // Register reset values.
    localparam logic [3:0]  STRIP_WIDTH_RST  = 4'd5;
    localparam logic [15:0] COLUMN_COUNT_RST = 16'd2000;

    // Register indexes, taken from paddr[2].
    localparam logic REG_STRIP_WIDTH  = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    // Cell hash constants.
    localparam logic [31:0] ROW_MUL     = 32'd2654435761;
    localparam logic [15:0] COL_MUL     = 16'd40503;
    localparam logic [31:0] HASH_ADD    = 32'd12345;
    localparam logic [63:0] HASH_OFFSET = 64'd1469598103934665603;
    // The 64-bit prime is 2^PRIME_SHIFT + PRIME_LO.
    localparam int          PRIME_SHIFT = 40;
    localparam logic [8:0]  PRIME_LO    = 9'd435;
    localparam int          FOLD_SHIFT  = 33;

    // Residue unit: restoring reduction, several bits per cycle.
    localparam logic [30:0] RESIDUE_MOD       = 31'd1000000007;
    localparam int          MOD_BITS_PER_STEP = 5;
    localparam int          MOD_STEPS         = 7;
    localparam int          MOD_LOW_BITS      = MOD_BITS_PER_STEP * MOD_STEPS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MIX,
        ST_LOAD,
        ST_REDUCE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic seed_en;
        logic mix_en;
        logic mod_start;
    } hdsr_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/hashed_defect_strip_reachability_core.sv @@
// Top level: config registers, column/row scan sequencer and result register.
//
// Usage: each input beat on s_* carries a start row and a defect threshold;
// the block answers with one output beat on m_* whose bit 0 is 1 when a
// left-to-right path crosses all column_count columns of the strip.
// Registers are written over the APB port, strip_width at 0x0 and
// column_count at 0x4; the user must write them only while the block is
// idle, which the block itself does not enforce. pready is tied high.
// s_tready is high only while no query is in work; one query at a time.
// Work per query: each cell whose row has a reachable neighbor passes
// through the seed product, the prime multiply, the residue load and the
// residue steps of 5 bits each in the residue unit; a cell with no
// reachable neighbor is only scanned, and each column end is a scan step
// of its own. Each query also passes through the accept state and the
// result state; the scan ends early once no row stays reachable.
// The result waits in an output register; a new query is taken while it
// waits, and a finished query holds until m_tready frees that register.
// Reset clears the sequencer and restores strip_width 5, column_count 2000.
`default_nettype none

module hashed_defect_strip_reachability_core #(
    parameter int MAX_STRIP_WIDTH = hdsr_pkg::DEFAULT_MAX_STRIP_WIDTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_tdata: [15:0] start_row, [45:16] defect_threshold, [47:46] zero
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,
    // m_tdata: [0] channel_intact, [7:1] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int MW    = MAX_STRIP_WIDTH;
    localparam int ROW_W = $clog2(MW + 1);
    localparam int IDX_W = (MW > 1) ? $clog2(MW) : 1;

    // Configuration
    logic [3:0]  strip_width_reg;
    logic [15:0] column_count_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_width_reg  <= hdsr_pkg::STRIP_WIDTH_RST;
            column_count_reg <= hdsr_pkg::COLUMN_COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                hdsr_pkg::REG_STRIP_WIDTH:  strip_width_reg  <= pwdata[3:0];
                hdsr_pkg::REG_COLUMN_COUNT: column_count_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            hdsr_pkg::REG_STRIP_WIDTH:  prdata = {28'd0, strip_width_reg};
            hdsr_pkg::REG_COLUMN_COUNT: prdata = {16'd0, column_count_reg};
            default:                    prdata = '0;
        endcase
    end

    // Strip height saturated to the build maximum
    logic [31:0]      sw_ext;
    logic [ROW_W-1:0] eff_cfg;
    logic [MW-1:0]    cfg_mask;

    assign sw_ext   = {28'd0, strip_width_reg};
    assign eff_cfg  = (sw_ext > 32'(MW)) ? ROW_W'(MW) : ROW_W'(sw_ext);
    assign cfg_mask = ~({MW{1'b1}} << eff_cfg);

    // Scan state
    hdsr_pkg::state_t state_reg, state_next;
    logic [15:0]      start_reg, start_next;
    logic [29:0]      thr_reg, thr_next;
    logic [ROW_W-1:0] eff_reg, eff_next;
    logic [MW-1:0]    reach_reg, reach_next;
    logic [MW-1:0]    next_rows_reg, next_rows_next;
    logic [15:0]      col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             intact_reg, intact_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_bit_reg, out_bit_next;

    logic [MW-1:0]    nbr;
    logic [IDX_W-1:0] idx;
    logic [16:0]      cell_row;
    logic [63:0]      fold;
    logic             mod_done;
    logic [29:0]      residue;
    hdsr_pkg::hdsr_ctrl_t ctrl;

    // Row j is fed by rows j-1, j and j+1.
    assign nbr      = reach_reg | (reach_reg << 1) | (reach_reg >> 1);
    assign idx      = row_reg[IDX_W-1:0];
    assign cell_row = {1'b0, start_reg} + 17'(row_reg);

    assign s_tready = (state_reg == hdsr_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_bit_reg};

    hdsr_hash u_hash (
        .clk  (clk),
        .ctrl (ctrl),
        .row  (cell_row),
        .col  (col_reg),
        .fold (fold)
    );

    hdsr_mod u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctrl.mod_start),
        .value   (fold),
        .done    (mod_done),
        .residue (residue)
    );

    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        thr_next       = thr_reg;
        eff_next       = eff_reg;
        reach_next     = reach_reg;
        next_rows_next = next_rows_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        intact_next    = intact_reg;
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        ctrl           = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            hdsr_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    start_next     = s_tdata[15:0];
                    thr_next       = s_tdata[45:16];
                    eff_next       = eff_cfg;
                    reach_next     = cfg_mask;
                    next_rows_next = '0;
                    col_next       = '0;
                    row_next       = '0;
                    if (column_count_reg == 16'd0)
                    begin
                        intact_next = 1'b1;
                        state_next  = hdsr_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = hdsr_pkg::ST_SCAN;
                    end
                end
            end
            hdsr_pkg::ST_SCAN:
            begin
                if (row_reg == eff_reg)
                begin
                    // column end
                    reach_next     = next_rows_reg;
                    next_rows_next = '0;
                    row_next       = '0;
                    if (next_rows_reg == '0)
                    begin
                        intact_next = 1'b0;
                        state_next  = hdsr_pkg::ST_DONE;
                    end
                    else if (({1'b0, col_reg} + 17'd1) == {1'b0, column_count_reg})
                    begin
                        intact_next = 1'b1;
                        state_next  = hdsr_pkg::ST_DONE;
                    end
                    else
                    begin
                        col_next = col_reg + 16'd1;
                    end
                end
                else if (nbr[idx])
                begin
                    ctrl.seed_en = 1'b1;
                    state_next   = hdsr_pkg::ST_MIX;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            hdsr_pkg::ST_MIX:
            begin
                ctrl.mix_en = 1'b1;
                state_next  = hdsr_pkg::ST_LOAD;
            end
            hdsr_pkg::ST_LOAD:
            begin
                ctrl.mod_start = 1'b1;
                state_next     = hdsr_pkg::ST_REDUCE;
            end
            hdsr_pkg::ST_REDUCE:
            begin
                if (mod_done)
                begin
                    if (residue >= thr_reg)
                    begin
                        next_rows_next[idx] = 1'b1;
                    end
                    row_next   = row_reg + ROW_W'(1);
                    state_next = hdsr_pkg::ST_SCAN;
                end
            end
            hdsr_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_bit_next   = intact_reg;
                    state_next     = hdsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hdsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hdsr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            reach_reg     <= '0;
            next_rows_reg <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            eff_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            reach_reg     <= reach_next;
            next_rows_reg <= next_rows_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            eff_reg       <= eff_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg   <= start_next;
        thr_reg     <= thr_next;
        intact_reg  <= intact_next;
        out_bit_reg <= out_bit_next;
    end

    // Residue unit finishes only while the sequencer waits on it.
    a_done_in_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == hdsr_pkg::ST_REDUCE))
        else $error("residue done outside reduce state");

    // Reachable rows never extend past the latched strip height.
    a_reach_in_strip: assert property (@(posedge clk) disable iff (!rst_n)
        (reach_reg & ({MW{1'b1}} << eff_reg)) == '0)
        else $error("reachable row outside strip");

    // A row enters the next column only next to a reachable row.
    a_next_fed: assert property (@(posedge clk) disable iff (!rst_n)
        (next_rows_reg & ~nbr) == '0)
        else $error("next row without feeder");

    // An accepted query closes the input side on the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready after accept");

endmodule

`default_nettype wire

@@ rtl/core/hdsr_hash.sv @@
// Two-stage cell hash: seed product, then offset xor and prime multiply.
`default_nettype none

module hdsr_hash (
    input  wire logic               clk,
    input  wire hdsr_pkg::hdsr_ctrl_t ctrl,
    input  wire logic [16:0]        row,
    input  wire logic [15:0]        col,
    output logic      [63:0]        fold
);

    logic [31:0] seed_reg;
    logic [31:0] seed_next;
    logic [63:0] x_reg;
    logic [63:0] x_next;
    logic [31:0] row_prod;
    logic [31:0] col_prod;
    logic [63:0] x0;

    assign row_prod  = 32'({15'd0, row} * hdsr_pkg::ROW_MUL);
    assign col_prod  = {16'd0, col} * {16'd0, hdsr_pkg::COL_MUL};
    assign seed_next = row_prod + col_prod + hdsr_pkg::HASH_ADD;

    // x * prime mod 2^64 as a shift plus a narrow product
    assign x0     = hdsr_pkg::HASH_OFFSET ^ {32'd0, seed_reg};
    assign x_next = (x0 << hdsr_pkg::PRIME_SHIFT) + (x0 * {55'd0, hdsr_pkg::PRIME_LO});

    assign fold = x_reg ^ (x_reg >> hdsr_pkg::FOLD_SHIFT);

    always_ff @(posedge clk)
    begin
        if (ctrl.seed_en)
        begin
            seed_reg <= seed_next;
        end
        if (ctrl.mix_en)
        begin
            x_reg <= x_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/hdsr_mod.sv @@
// Iterative residue unit: 64-bit value modulo the residue prime.
`default_nettype none

module hdsr_mod (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] value,
    output logic             done,
    output logic      [29:0] residue
);

    localparam int CNT_W = (hdsr_pkg::MOD_STEPS > 1) ? $clog2(hdsr_pkg::MOD_STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(hdsr_pkg::MOD_STEPS - 1);
    localparam int LOW = hdsr_pkg::MOD_LOW_BITS;

    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [29:0]      rem_reg;
    logic [29:0]      rem_next;
    logic [LOW-1:0]   bits_reg;
    logic [LOW-1:0]   bits_next;
    logic [29:0]      rem_step;

    // Top bits start below the modulus; each step shifts in one bit and
    // subtracts once, so the partial remainder stays below the modulus.
    always_comb
    begin
        logic [30:0] trial;
        logic [29:0] t;
        t = rem_reg;
        for (int i = 0; i < hdsr_pkg::MOD_BITS_PER_STEP; i++)
        begin
            trial = {t, bits_reg[LOW-1-i]};
            if (trial >= hdsr_pkg::RESIDUE_MOD)
            begin
                trial = trial - hdsr_pkg::RESIDUE_MOD;
            end
            t = trial[29:0];
        end
        rem_step = t;
    end

    assign done    = busy_reg && (cnt_reg == LAST);
    assign residue = rem_step;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        bits_next = bits_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = 30'(value[63:LOW]);
            bits_next = value[LOW-1:0];
        end
        else if (busy_reg)
        begin
            rem_next  = rem_step;
            bits_next = bits_reg << hdsr_pkg::MOD_BITS_PER_STEP;
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
    end

endmodule

`default_nettype wire
